### design/sha_pkg.sv
// SHA-256 hasher package: round constants, initial hash, helpers, queue types.
// Depends on nothing.
`timescale 1ns / 1ps
package sha_pkg;
    localparam int QUEUE_DEPTH = 4;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       byte_present;
        logic       end_of_message;
        logic       restart;
    } cmd_t;

    typedef logic [31:0] word_t;

    function automatic word_t round_k(input logic [5:0] r);
        word_t k;
        case (r)
            6'd0: k = 32'h428a2f98; 6'd1: k = 32'h71374491; 6'd2: k = 32'hb5c0fbcf;
            6'd3: k = 32'he9b5dba5; 6'd4: k = 32'h3956c25b; 6'd5: k = 32'h59f111f1;
            6'd6: k = 32'h923f82a4; 6'd7: k = 32'hab1c5ed5; 6'd8: k = 32'hd807aa98;
            6'd9: k = 32'h12835b01; 6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
            6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe; 6'd14: k = 32'h9bdc06a7;
            6'd15: k = 32'hc19bf174; 6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
            6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc; 6'd20: k = 32'h2de92c6f;
            6'd21: k = 32'h4a7484aa; 6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
            6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d; 6'd26: k = 32'hb00327c8;
            6'd27: k = 32'hbf597fc7; 6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
            6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967; 6'd32: k = 32'h27b70a85;
            6'd33: k = 32'h2e1b2138; 6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
            6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb; 6'd38: k = 32'h81c2c92e;
            6'd39: k = 32'h92722c85; 6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
            6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3; 6'd44: k = 32'hd192e819;
            6'd45: k = 32'hd6990624; 6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
            6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08; 6'd50: k = 32'h2748774c;
            6'd51: k = 32'h34b0bcb5; 6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
            6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3; 6'd56: k = 32'h748f82ee;
            6'd57: k = 32'h78a5636f; 6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
            6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb; 6'd62: k = 32'hbef9a3f7;
            default: k = 32'hc67178f2;
        endcase
        return k;
    endfunction

    function automatic word_t init_h(input logic [2:0] i);
        word_t h;
        case (i)
            3'd0: h = 32'h6a09e667; 3'd1: h = 32'hbb67ae85;
            3'd2: h = 32'h3c6ef372; 3'd3: h = 32'ha54ff53a;
            3'd4: h = 32'h510e527f; 3'd5: h = 32'h9b05688c;
            3'd6: h = 32'h1f83d9ab; default: h = 32'h5be0cd19;
        endcase
        return h;
    endfunction

    function automatic word_t ror(input word_t v, input int s);
        return (v >> s) | (v << (32 - s));
    endfunction
endpackage

### design/sha_if.sv
// Valid/ready channel interfaces for the hasher input and digest output.
// Depends on nothing.
`timescale 1ns / 1ps
interface sha_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       byte_present;
    logic       end_of_message;
    logic       restart;
    modport source (output valid, data_byte, byte_present, end_of_message, restart,
                    input ready);
    modport sink (input valid, data_byte, byte_present, end_of_message, restart,
                  output ready);
endinterface

interface sha_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
    modport source (output valid, digest_word, word_index, last_word, input ready);
    modport sink (input valid, digest_word, word_index, last_word, output ready);
endinterface

### design/sha_queue.sv
// Short word queue between the front end and the hashing engine.
// Depends on sha_pkg.
`timescale 1ns / 1ps
module sha_queue
    import sha_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t push_data,
    output logic full,
    input  logic pop,
    output cmd_t pop_data,
    output logic empty
);
    localparam int AW = $clog2(DEPTH);
    cmd_t mem [DEPTH];
    logic [AW-1:0] wr_reg, rd_reg;
    logic [AW:0]   cnt_reg;

    assign full     = (cnt_reg == (AW+1)'(DEPTH));
    assign empty    = (cnt_reg == '0);
    assign pop_data = mem[rd_reg];

    // store word
    always_ff @(posedge clk)
    begin
        if (push && !full)
        begin
            mem[wr_reg] <= push_data;
        end
    end

    // advance pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push && !full)
            begin
                wr_reg <= (wr_reg == AW'(DEPTH - 1)) ? '0 : wr_reg + 1'b1;
            end
            if (pop && !empty)
            begin
                rd_reg <= (rd_reg == AW'(DEPTH - 1)) ? '0 : rd_reg + 1'b1;
            end
            cnt_reg <= cnt_reg + (AW+1)'(push && !full) - (AW+1)'(pop && !empty);
        end
    end
endmodule

### design/sha_engine.sv
// Back end: block packing, padding, 64-round compression and digest output.
// Depends on sha_pkg and sha_out_if.
`timescale 1ns / 1ps
module sha_engine
    import sha_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  cmd_t  cmd,
    input  logic  cmd_valid,
    output logic  cmd_pop,
    sha_out_if.source out
);
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_PAD  = 3'd1;
    localparam logic [2:0] S_LOAD = 3'd2;
    localparam logic [2:0] S_RND  = 3'd3;
    localparam logic [2:0] S_ADD  = 3'd4;
    localparam logic [2:0] S_OUT  = 3'd5;

    logic [2:0]  state_reg;
    word_t       blk [16];
    word_t       w_reg [16];
    word_t       h_reg [8];
    word_t       v_reg [8];
    logic [63:0] cnt_reg;
    logic [5:0]  pos_reg;
    logic [5:0]  rnd_reg;
    logic [2:0]  oidx_reg;
    logic        final_reg;   // padding is under way, digest follows
    logic        lenblk_reg;  // the block being filled carries the length
    logic        mark_reg;    // next pad byte is the 0x80 marker
    logic        ovalid_reg;

    word_t wr, t1, t2, g0, g1;
    logic [63:0] bits;
    logic [63:0] c_base;
    logic [63:0] c_next;
    logic        blk_full;
    logic [7:0]  pad_byte;

    assign bits = {cnt_reg[60:0], 3'b000};

    // byte count after this word and whether its byte closes a block
    always_comb
    begin
        c_base   = cmd.restart ? 64'd0 : cnt_reg;
        c_next   = c_base + 64'(cmd.byte_present);
        blk_full = cmd.byte_present && (c_base[5:0] == 6'd63);
    end

    // pick the pad byte: marker, length byte or zero
    always_comb
    begin
        if (mark_reg)
        begin
            pad_byte = 8'h80;
        end
        else if (lenblk_reg && pos_reg >= 6'd56)
        begin
            pad_byte = bits[{~pos_reg[2:0], 3'b000} +: 8];
        end
        else
        begin
            pad_byte = 8'h00;
        end
    end

    // message schedule and round function
    always_comb
    begin
        g0 = ror(w_reg[1], 7) ^ ror(w_reg[1], 18) ^ (w_reg[1] >> 3);
        g1 = ror(w_reg[14], 17) ^ ror(w_reg[14], 19) ^ (w_reg[14] >> 10);
        wr = w_reg[0];
        t1 = v_reg[7] + (ror(v_reg[4], 6) ^ ror(v_reg[4], 11) ^ ror(v_reg[4], 25))
             + ((v_reg[4] & v_reg[5]) ^ (~v_reg[4] & v_reg[6])) + round_k(rnd_reg) + wr;
        t2 = (ror(v_reg[0], 2) ^ ror(v_reg[0], 13) ^ ror(v_reg[0], 22))
             + ((v_reg[0] & v_reg[1]) ^ (v_reg[0] & v_reg[2]) ^ (v_reg[1] & v_reg[2]));
    end

    assign cmd_pop         = (state_reg == S_IDLE) && cmd_valid;
    assign out.valid       = ovalid_reg;
    assign out.digest_word = h_reg[oidx_reg];
    assign out.word_index  = oidx_reg;
    assign out.last_word   = (oidx_reg == 3'd7);

    // block buffer: one byte lane per cycle while idle or padding, big-endian within each word
    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && cmd_valid && cmd.byte_present)
        begin
            blk[c_base[5:2]][{~c_base[1:0], 3'b000} +: 8] <= cmd.data_byte;
        end
        else if (state_reg == S_PAD)
        begin
            blk[pos_reg[5:2]][{~pos_reg[1:0], 3'b000} +: 8] <= pad_byte;
        end
    end

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            cnt_reg    <= '0;
            ovalid_reg <= 1'b0;
            oidx_reg   <= '0;
            pos_reg    <= '0;
            rnd_reg    <= '0;
            final_reg  <= 1'b0;
            lenblk_reg <= 1'b0;
            mark_reg   <= 1'b0;
            for (int i = 0; i < 8; i++)
            begin
                h_reg[i] <= init_h(3'(i));
            end
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (cmd_valid)
                    begin
                        if (cmd.restart)
                        begin
                            for (int i = 0; i < 8; i++)
                            begin
                                h_reg[i] <= init_h(3'(i));
                            end
                        end
                        cnt_reg <= c_next;
                        if (cmd.end_of_message)
                        begin
                            // marker goes at the next free position during the pad fill;
                            // a block just filled by this byte is compressed first
                            final_reg  <= 1'b1;
                            mark_reg   <= 1'b1;
                            pos_reg    <= c_next[5:0];
                            lenblk_reg <= !blk_full && (c_next[5:0] < 6'd56);
                            state_reg  <= blk_full ? S_LOAD : S_PAD;
                        end
                        else if (blk_full)
                        begin
                            state_reg <= S_LOAD;
                        end
                    end
                end
                S_PAD:
                begin
                    mark_reg <= 1'b0;
                    pos_reg  <= pos_reg + 6'd1;
                    if (pos_reg == 6'd63)
                    begin
                        state_reg <= S_LOAD;
                    end
                end
                S_LOAD:
                begin
                    for (int j = 0; j < 16; j++)
                    begin
                        w_reg[j] <= blk[j];
                    end
                    for (int j = 0; j < 8; j++)
                    begin
                        v_reg[j] <= h_reg[j];
                    end
                    rnd_reg   <= '0;
                    state_reg <= S_RND;
                end
                S_RND:
                begin
                    for (int j = 0; j < 15; j++)
                    begin
                        w_reg[j] <= w_reg[j+1];
                    end
                    w_reg[15] <= w_reg[0] + g0 + w_reg[9] + g1;
                    v_reg[7] <= v_reg[6];
                    v_reg[6] <= v_reg[5];
                    v_reg[5] <= v_reg[4];
                    v_reg[4] <= v_reg[3] + t1;
                    v_reg[3] <= v_reg[2];
                    v_reg[2] <= v_reg[1];
                    v_reg[1] <= v_reg[0];
                    v_reg[0] <= t1 + t2;
                    rnd_reg  <= rnd_reg + 6'd1;
                    if (rnd_reg == 6'd63)
                    begin
                        state_reg <= S_ADD;
                    end
                end
                S_ADD:
                begin
                    for (int j = 0; j < 8; j++)
                    begin
                        h_reg[j] <= h_reg[j] + v_reg[j];
                    end
                    if (!final_reg)
                    begin
                        state_reg <= S_IDLE;
                    end
                    else if (!lenblk_reg)
                    begin
                        // fill the block that carries the length
                        lenblk_reg <= 1'b1;
                        pos_reg    <= 6'd0;
                        state_reg  <= S_PAD;
                    end
                    else
                    begin
                        final_reg  <= 1'b0;
                        cnt_reg    <= '0;
                        oidx_reg   <= '0;
                        ovalid_reg <= 1'b1;
                        state_reg  <= S_OUT;
                    end
                end
                S_OUT:
                begin
                    if (out.ready)
                    begin
                        oidx_reg <= oidx_reg + 3'd1;
                        if (oidx_reg == 3'd7)
                        begin
                            ovalid_reg <= 1'b0;
                            state_reg  <= S_IDLE;
                        end
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end
endmodule

### design/sha256_message_hasher.sv
// Top level of the SHA-256 message hasher: front end, queue and engine.
// Depends on sha_pkg, sha_if, sha_queue and sha_engine.
//
// Usage: the input channel takes one word per handshake: a message byte
// with byte_present, end_of_message and restart flags. Bytes pack
// big-endian into 64-byte blocks; a full block runs 64 rounds, one per
// cycle, in the engine's round unit, between the load of the schedule
// and working registers and the add into the hash values. A closing word
// pads the message (0x80, zeros, 64-bit bit length) and the engine then
// shows eight 32-bit digest words on the output channel, index 0 first,
// last_word on the eighth. The engine takes one byte per cycle while it
// is idle and none while it pads, compresses or sends the digest. Closing
// adds a pad fill of the byte positions left in the block (at most 64)
// and one compression, or a second fill and compression when the length
// spills; the first digest word shows the cycle after the last add.
// The input side keeps accepting into a four-entry queue while the engine
// works or the receiver stalls; ready falls only when the queue fills.
// Output words hold while ready is low. Reset reloads the initial hash
// values and clears the byte count; the block buffer needs no clearing.
`timescale 1ns / 1ps
module sha256_message_hasher
    import sha_pkg::*;
#(
    parameter int QDEPTH = QUEUE_DEPTH
) (
    input logic clk,
    input logic rst_n,
    sha_in_if.sink    in_ch,
    sha_out_if.source out_ch
);
    cmd_t qin, qout;
    logic full, empty, pop;

    // classify and pack the incoming word
    always_comb
    begin
        qin.data_byte      = in_ch.data_byte;
        qin.byte_present   = in_ch.byte_present;
        qin.end_of_message = in_ch.end_of_message;
        qin.restart        = in_ch.restart;
    end
    assign in_ch.ready = !full;

    sha_queue #(.DEPTH(QDEPTH)) u_queue (
        .clk, .rst_n,
        .push(in_ch.valid), .push_data(qin), .full,
        .pop, .pop_data(qout), .empty
    );

    sha_engine u_engine (
        .clk, .rst_n,
        .cmd(qout), .cmd_valid(!empty), .cmd_pop(pop),
        .out(out_ch)
    );
endmodule

### design/sha_checker.sv
// Port-level checks for the SHA-256 hasher, bound to the top level.
// Depends on the top level and its output channel interface.
`timescale 1ns / 1ps
module sha_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        ovalid,
    input logic        oready,
    input logic [2:0]  oidx,
    input logic        olast
);
    a_last: assert property (@(posedge clk) disable iff (!rst_n)
        ovalid |-> (olast == (oidx == 3'd7)))
        else $error("last_word mismatch");
    a_step: assert property (@(posedge clk) disable iff (!rst_n)
        (ovalid && oready && oidx != 3'd7) |=> (ovalid && oidx == $past(oidx) + 3'd1))
        else $error("digest words out of order");
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (ovalid && !oready) |=> (ovalid && $stable(oidx)))
        else $error("output dropped while stalled");
endmodule

bind sha256_message_hasher sha_checker u_checker (
    .clk(clk), .rst_n(rst_n), .ovalid(out_ch.valid), .oready(out_ch.ready),
    .oidx(out_ch.word_index), .olast(out_ch.last_word)
);
